### src/tvpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tvpt_pkg;

    // Command codes
    typedef enum logic [1:0] {
        CMD_QUERY = 2'd0,
        CMD_WR_TRIG = 2'd1,
        CMD_WR_PLANE = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    // Configuration register indexes
    localparam logic [0:0] REG_TRIGGER_COUNT = 1'b0;
    localparam logic [0:0] REG_PLANE_TOTAL = 1'b1;

    // Trigger entry: min corner, max corner, first plane
    typedef struct packed {
        logic [31:0] min_x;
        logic [31:0] min_y;
        logic [31:0] min_z;
        logic [31:0] max_x;
        logic [31:0] max_y;
        logic [31:0] max_z;
        logic [15:0] first;
    } t_trig;

    // Plane entry: offset and normal, 16 bits each
    typedef struct packed {
        logic [15:0] off_x;
        logic [15:0] off_y;
        logic [15:0] off_z;
        logic [15:0] nrm_x;
        logic [15:0] nrm_y;
        logic [15:0] nrm_z;
    } t_plane;

endpackage
`default_nettype wire

### src/trigger_volume_point_test.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | direction | handshake
// command   | in        | i_start / o_busy; accepted when i_start && !o_busy
// result    | out       | o_valid strobe, one cycle, cannot be stalled
// config    | in        | i_cfg_valid / o_cfg_ready (always ready)
//
// Writes leave the block idle. A query reads the trigger entries and runs
// the box check, then walks its planes: the single plane memory port is
// read, then three wrapped differences and three 16x32 products are
// registered in turn, then a 64-bit sum and sign test; one more check
// closes the walk. A query stops early when a plane rejects the point.
// Synchronous active-low reset clears control state only; store contents
// are undefined until written. Results cannot be held off by the receiver.
module trigger_volume_point_test #(
    parameter int MAX_TRIGGERS = 255,
    parameter int MAX_PLANES = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire  [1:0]  i_command,
    input  wire  [9:0]  i_index,
    input  wire  [31:0] i_a_x,
    input  wire  [31:0] i_a_y,
    input  wire  [31:0] i_a_z,
    input  wire  [31:0] i_b_x,
    input  wire  [31:0] i_b_y,
    input  wire  [31:0] i_b_z,
    input  wire  [15:0] i_first_plane,
    output logic        o_valid,
    output logic        o_inside_res,
    output logic        o_index_ok,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [10:0] i_cfg_data
);
    localparam int TSLOTS = MAX_TRIGGERS + 1;
    localparam int TAW = (TSLOTS > 1) ? $clog2(TSLOTS) : 1;
    localparam int PAW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RDT   = 7'b0000010,
        S_BOX   = 7'b0000100,
        S_PRD   = 7'b0001000,
        S_DIFF  = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_SUM   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Configuration
    logic [7:0]  r_trig_count;
    logic [10:0] r_plane_total;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_count <= '0;
            r_plane_total <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == tvpt_pkg::REG_TRIGGER_COUNT) r_trig_count <= i_cfg_data[7:0];
            else r_plane_total <= i_cfg_data;
        end
    end

    // Memories
    tvpt_pkg::t_trig  trig_mem [TSLOTS];
    tvpt_pkg::t_plane plane_mem [MAX_PLANES];

    logic accept;
    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != S_IDLE);

    wire [9:0] idx_ext = i_index;
    logic trig_wr_ok, plane_wr_ok;
    assign trig_wr_ok = (32'(idx_ext) < 32'(TSLOTS));
    assign plane_wr_ok = (32'(idx_ext) < 32'(MAX_PLANES));

    // Query registers
    logic [TAW-1:0] r_t;
    logic           r_t_last;   // t+1 not a valid slot
    logic           r_ok;
    logic [31:0]    r_px, r_py, r_pz;
    logic [TAW-1:0] trig_raddr;
    tvpt_pkg::t_trig r_trig_rd;
    tvpt_pkg::t_trig r_cur;
    logic [15:0]    r_k, r_last;
    logic [PAW-1:0] plane_raddr;
    tvpt_pkg::t_plane r_pl;
    logic [31:0]    r_dx, r_dy, r_dz;
    logic [15:0]    r_nx, r_ny, r_nz;
    logic signed [47:0] r_mx, r_my, r_mz;

    // Trigger memory port
    always_ff @(posedge i_clk) begin
        if (accept && i_command == tvpt_pkg::CMD_WR_TRIG && trig_wr_ok)
            trig_mem[i_index[TAW-1:0]] <= {i_a_x, i_a_y, i_a_z,
                                           i_b_x, i_b_y, i_b_z, i_first_plane};
        r_trig_rd <= trig_mem[trig_raddr];
    end

    // Plane memory port
    always_ff @(posedge i_clk) begin
        if (accept && i_command == tvpt_pkg::CMD_WR_PLANE && plane_wr_ok)
            plane_mem[i_index[PAW-1:0]] <= {i_a_x[15:0], i_a_y[15:0], i_a_z[15:0],
                                            i_b_x[15:0], i_b_y[15:0], i_b_z[15:0]};
        r_pl <= plane_mem[plane_raddr];
    end

    assign plane_raddr = r_k[PAW-1:0];
    always_comb begin
        if (r_state == S_IDLE) trig_raddr = i_index[TAW-1:0];
        else trig_raddr = r_t + TAW'(1);
    end

    // Box test and plane range
    logic in_box;
    assign in_box = !($signed(r_px) < $signed(r_trig_rd.min_x) ||
                      $signed(r_px) > $signed(r_trig_rd.max_x) ||
                      $signed(r_py) < $signed(r_trig_rd.min_y) ||
                      $signed(r_py) > $signed(r_trig_rd.max_y) ||
                      $signed(r_pz) < $signed(r_trig_rd.min_z) ||
                      $signed(r_pz) > $signed(r_trig_rd.max_z));
    logic [16:0] limit;
    assign limit = (32'(r_plane_total) < 32'(MAX_PLANES)) ? 17'(r_plane_total)
                                                           : 17'(MAX_PLANES);
    logic [15:0] last_cl;
    assign last_cl = (17'(r_trig_rd.first) > limit) ? limit[15:0] : r_trig_rd.first;

    logic signed [63:0] dot;
    assign dot = 64'(r_mx) + 64'(r_my) + 64'(r_mz);

    logic        n_valid, n_inside;
    logic        r_valid, r_inside, r_okout;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        if (n_valid) begin
            r_inside <= n_inside;
            r_okout <= r_ok;
        end
        if (accept) begin
            r_t <= i_index[TAW-1:0];
            r_t_last <= !(32'(idx_ext) + 32'd1 < 32'(TSLOTS));
            r_ok <= (idx_ext <= 10'(r_trig_count)) && trig_wr_ok;
            r_px <= i_a_x;
            r_py <= i_a_y;
            r_pz <= i_a_z;
        end
        unique case (r_state)
            S_RDT: r_cur <= r_trig_rd;
            S_BOX: begin
                r_k <= r_cur.first;
                r_last <= last_cl;
            end
            S_SUM: r_k <= r_k + 16'd1;
            S_DIFF: begin
                r_dx <= r_px - (r_cur.min_x + {{16{r_pl.off_x[15]}}, r_pl.off_x});
                r_dy <= r_py - (r_cur.min_y + {{16{r_pl.off_y[15]}}, r_pl.off_y});
                r_dz <= r_pz - (r_cur.min_z + {{16{r_pl.off_z[15]}}, r_pl.off_z});
                r_nx <= r_pl.nrm_x;
                r_ny <= r_pl.nrm_y;
                r_nz <= r_pl.nrm_z;
            end
            S_MUL: begin
                r_mx <= $signed(r_nx) * $signed(r_dx);
                r_my <= $signed(r_ny) * $signed(r_dy);
                r_mz <= $signed(r_nz) * $signed(r_dz);
            end
            default: ;
        endcase
    end

    // r_cur holds the trigger entry; r_trig_rd in S_BOX holds entry t+1
    logic box_now;
    assign box_now = !($signed(r_px) < $signed(r_cur.min_x) ||
                       $signed(r_px) > $signed(r_cur.max_x) ||
                       $signed(r_py) < $signed(r_cur.min_y) ||
                       $signed(r_py) > $signed(r_cur.max_y) ||
                       $signed(r_pz) < $signed(r_cur.min_z) ||
                       $signed(r_pz) > $signed(r_cur.max_z));

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_inside = 1'b0;
        unique case (r_state)
            S_IDLE: if (accept && i_command == tvpt_pkg::CMD_QUERY) n_state = S_RDT;
            S_RDT: begin
                // entry t now in r_trig_rd and box-checked here; S_BOX reuses it via r_cur
                if (!r_ok) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (!in_box) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (32'(r_t) >= 32'(r_trig_count) || r_t_last) begin
                    n_valid = 1'b1;
                    n_inside = 1'b1;
                    n_state = S_IDLE;
                end else n_state = S_BOX;
            end
            S_BOX: begin
                if (r_trig_rd.first <= r_cur.first || r_cur.first >= last_cl) begin
                    n_valid = 1'b1;
                    n_inside = box_now;
                    n_state = S_IDLE;
                end else n_state = S_PRD;
            end
            S_PRD: begin
                if (r_k >= r_last) begin
                    n_valid = 1'b1;
                    n_inside = 1'b1;
                    n_state = S_IDLE;
                end else n_state = S_DIFF;
            end
            S_DIFF: n_state = S_MUL;
            S_MUL: n_state = S_SUM;
            S_SUM: begin
                if (dot > 64'sd0) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else n_state = S_PRD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid = r_valid;
    assign o_inside_res = r_inside;
    assign o_index_ok = r_okout;
endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int TRIG_SLOTS = 256;
    localparam int PLANE_SLOTS = 1024;
    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_LIMIT = 40000;

    // One command item as driven on the ports
    typedef struct {
        tvpt_pkg::t_cmd cmd;
        logic [9:0]  idx;
        logic [31:0] a [3];
        logic [31:0] b [3];
        logic [15:0] first;
    } t_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_command;
    logic [9:0]  i_index;
    logic [31:0] i_a_x, i_a_y, i_a_z;
    logic [31:0] i_b_x, i_b_y, i_b_z;
    logic [15:0] i_first_plane;
    logic        o_valid;
    logic        o_inside_res;
    logic        o_index_ok;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [10:0] i_cfg_data;

    trigger_volume_point_test u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_command     (i_command),
        .i_index       (i_index),
        .i_a_x         (i_a_x),
        .i_a_y         (i_a_y),
        .i_a_z         (i_a_z),
        .i_b_x         (i_b_x),
        .i_b_y         (i_b_y),
        .i_b_z         (i_b_z),
        .i_first_plane (i_first_plane),
        .o_valid       (o_valid),
        .o_inside_res  (o_inside_res),
        .o_index_ok    (o_index_ok),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Shadow copy of the block's tables and registers
    logic [31:0] box_lo   [TRIG_SLOTS][3];
    logic [31:0] box_hi   [TRIG_SLOTS][3];
    logic [15:0] span_at  [TRIG_SLOTS];
    logic [15:0] pl_off   [PLANE_SLOTS][3];
    logic [15:0] pl_nrm   [PLANE_SLOTS][3];
    logic [7:0]  trig_count_sh;
    logic [10:0] plane_total_sh;

    t_item       pending_items [$];
    logic [1:0]  expected_hits [$];   // {inside_res, index_ok}
    int          errors;
    int          gap_pct;
    bit          burst;
    logic        took;
    int          cfg_writes;
    int          idle_cycles;
    int          sent_items;
    int          taken_items;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Expected answer of a point query against the shadow tables
    function automatic logic [1:0] point_hit(logic [9:0] t, logic [31:0] px,
                                             logic [31:0] py, logic [31:0] pz);
        logic [31:0] p [3];
        logic        ok;
        logic        hit;
        int unsigned first;
        int unsigned last;
        int unsigned lim;
        longint      dot;
        logic [31:0] world;
        logic [31:0] diff;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        ok = (t <= trig_count_sh);
        hit = ok;
        if (ok) begin
            for (int i = 0; i < 3; i++) begin
                if ($signed(p[i]) < $signed(box_lo[t][i]) ||
                    $signed(p[i]) > $signed(box_hi[t][i])) begin
                    hit = 1'b0;
                end
            end
        end
        // Planes only for real triggers, not the sentinel
        if (hit && t < trig_count_sh) begin
            first = span_at[t];
            last = span_at[t + 1];
            if (last > first) begin
                lim = (plane_total_sh < PLANE_SLOTS) ? plane_total_sh : PLANE_SLOTS;
                if (last > lim) begin
                    last = lim;
                end
                for (int unsigned k = first; k < last; k++) begin
                    dot = 0;
                    for (int i = 0; i < 3; i++) begin
                        world = box_lo[t][i] + {{16{pl_off[k][i][15]}}, pl_off[k][i]};
                        diff = p[i] - world;
                        dot += longint'($signed(pl_nrm[k][i])) * longint'($signed(diff));
                    end
                    if (dot > 0) begin
                        hit = 1'b0;
                    end
                end
            end
        end
        return {hit, ok};
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    // Driver: next item may go out at the falling edge after the last was taken, unless a random gap holds it
    always @(negedge i_clk) begin
        t_item it;
        if (i_rst_n && (!i_start || took)) begin
            if (pending_items.size() > 0 && (burst || $urandom_range(0, 99) >= gap_pct)) begin
                it = pending_items.pop_front();
                sent_items++;
                i_command <= it.cmd;
                i_index <= it.idx;
                i_a_x <= it.a[0];
                i_a_y <= it.a[1];
                i_a_z <= it.a[2];
                i_b_x <= it.b[0];
                i_b_y <= it.b[1];
                i_b_z <= it.b[2];
                i_first_plane <= it.first;
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
            if ($urandom_range(0, 49) == 0) begin
                burst <= ~burst;
            end
        end
    end

    // Monitor: shadow update on accepted items, result check, watchdog
    always @(posedge i_clk) begin
        logic [1:0] want;
        logic       active;
        took <= i_rst_n && i_start && !o_busy;
        active = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                active = 1'b1;
                cfg_writes <= cfg_writes + 1;
                if (i_cfg_index == tvpt_pkg::REG_TRIGGER_COUNT) begin
                    trig_count_sh = i_cfg_data[7:0];
                end else begin
                    plane_total_sh = i_cfg_data;
                end
            end
            if (o_valid) begin
                active = 1'b1;
                if (expected_hits.size() == 0) begin
                    report("result with no query outstanding");
                end else begin
                    want = expected_hits.pop_front();
                    if (o_inside_res !== want[1]) begin
                        report($sformatf("inside_res %b, expected %b", o_inside_res, want[1]));
                    end
                    if (o_index_ok !== want[0]) begin
                        report($sformatf("index_ok %b, expected %b", o_index_ok, want[0]));
                    end
                end
            end
            if (i_start && !o_busy) begin
                active = 1'b1;
                taken_items++;
                case (tvpt_pkg::t_cmd'(i_command))
                    tvpt_pkg::CMD_QUERY: begin
                        expected_hits.push_back(point_hit(i_index, i_a_x, i_a_y, i_a_z));
                    end
                    tvpt_pkg::CMD_WR_TRIG: begin
                        if (i_index < TRIG_SLOTS) begin
                            box_lo[i_index] = '{i_a_x, i_a_y, i_a_z};
                            box_hi[i_index] = '{i_b_x, i_b_y, i_b_z};
                            span_at[i_index] = i_first_plane;
                        end
                    end
                    tvpt_pkg::CMD_WR_PLANE: begin
                        pl_off[i_index] = '{i_a_x[15:0], i_a_y[15:0], i_a_z[15:0]};
                        pl_nrm[i_index] = '{i_b_x[15:0], i_b_y[15:0], i_b_z[15:0]};
                    end
                    default: begin
                    end
                endcase
            end
            idle_cycles <= active ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL trigger_volume_point_test");
                $finish;
            end
        end
    end

    task automatic push_item(tvpt_pkg::t_cmd cmd, logic [9:0] idx, logic [31:0] ax,
                             logic [31:0] ay, logic [31:0] az, logic [31:0] bx,
                             logic [31:0] by, logic [31:0] bz, logic [15:0] first);
        t_item it;
        it.cmd = cmd;
        it.idx = idx;
        it.a = '{ax, ay, az};
        it.b = '{bx, by, bz};
        it.first = first;
        pending_items.push_back(it);
    endtask

    // Wait until every item is out and taken and every result is back, then
    // let the last write finish inside the block
    task automatic drain();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_start || sent_items != taken_items ||
               o_busy || expected_hits.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [10:0] data);
        int seen;
        @(negedge i_clk);
        seen = cfg_writes;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(negedge i_clk);
        while (cfg_writes == seen);
        i_cfg_valid <= 1'b0;
    endtask

    // Random coordinate within [lo, hi] as signed values; any value if hi < lo
    function automatic logic [31:0] pick_between(logic [31:0] lo, logic [31:0] hi);
        longint l;
        longint h;
        longint r;
        l = longint'($signed(lo));
        h = longint'($signed(hi));
        if (h < l) begin
            return $urandom;
        end
        r = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % (h - l + 1);
        return 32'(l + r);
    endfunction

    task automatic push_trigger(logic [9:0] idx);
        logic [31:0] lo [3];
        logic [31:0] hi [3];
        logic [15:0] first;
        for (int i = 0; i < 3; i++) begin
            lo[i] = $urandom;
            hi[i] = ($urandom_range(0, 19) == 0) ? $urandom : lo[i] + $urandom_range(0, 1 << 20);
        end
        first = ($urandom_range(0, 32) == 0) ? 16'($urandom) :
                16'((idx % TRIG_SLOTS) * 4 + $urandom_range(0, 3));
        push_item(tvpt_pkg::CMD_WR_TRIG, idx, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                  first);
    endtask

    task automatic push_plane(logic [9:0] idx);
        logic [31:0] n [3];
        bit          flat;
        flat = ($urandom_range(0, 9) < 4);
        for (int i = 0; i < 3; i++) begin
            n[i] = (flat || $urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
        end
        push_item(tvpt_pkg::CMD_WR_PLANE, idx, $urandom, $urandom, $urandom,
                  n[0], n[1], n[2], 0);
    endtask

    task automatic push_query(logic [9:0] t);
        logic [31:0] p [3];
        for (int i = 0; i < 3; i++) begin
            p[i] = (t < TRIG_SLOTS && $urandom_range(0, 9) < 7) ?
                   pick_between(box_lo[t][i], box_hi[t][i]) : $urandom;
        end
        push_item(tvpt_pkg::CMD_QUERY, t, p[0], p[1], p[2], $urandom, $urandom, $urandom,
                  16'($urandom));
    endtask

    initial begin
        int          pcts [4];
        logic [9:0]  t;
        int          pick;
        pcts = '{0, 49, 0, 21};
        errors = 0;
        gap_pct = 0;
        burst = 1'b0;
        took = 1'b0;
        cfg_writes = 0;
        idle_cycles = 0;
        sent_items = 0;
        taken_items = 0;
        trig_count_sh = '0;
        plane_total_sh = '0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_command = tvpt_pkg::CMD_NONE;
        i_index = '0;
        i_a_x = '0;
        i_a_y = '0;
        i_a_z = '0;
        i_b_x = '0;
        i_b_y = '0;
        i_b_z = '0;
        i_first_plane = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = tvpt_pkg::REG_TRIGGER_COUNT;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill every table entry so that no query reads an unwritten one
        for (int i = 0; i < TRIG_SLOTS; i++) begin
            push_trigger(10'(i));
        end
        for (int k = 0; k < PLANE_SLOTS; k++) begin
            push_plane(10'(k));
        end
        drain();

        // Registers at zero: sentinel only, index too large, unknown command
        write_reg(tvpt_pkg::REG_TRIGGER_COUNT, 11'd0);
        write_reg(tvpt_pkg::REG_PLANE_TOTAL, 11'd0);
        push_item(tvpt_pkg::CMD_QUERY, 10'd0, box_lo[0][0], box_lo[0][1], box_lo[0][2],
                  0, 0, 0, 0);
        push_item(tvpt_pkg::CMD_QUERY, 10'd1, 0, 0, 0, 0, 0, 0, 0);
        push_item(tvpt_pkg::CMD_QUERY, 10'd1023, '1, '1, '1, '1, '1, '1, '1);
        push_item(tvpt_pkg::CMD_NONE, 10'd0, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // Full registers; writes out of range, extreme boxes, odd spans
        write_reg(tvpt_pkg::REG_TRIGGER_COUNT, 11'd255);
        write_reg(tvpt_pkg::REG_PLANE_TOTAL, 11'd1024);
        push_item(tvpt_pkg::CMD_WR_TRIG, 10'd300, 0, 0, 0, 0, 0, 0, 0);
        push_item(tvpt_pkg::CMD_WR_TRIG, 10'd1023, 0, 0, 0, 0, 0, 0, 0);
        push_item(tvpt_pkg::CMD_QUERY, 10'd255, 0, 0, 0, 0, 0, 0, 0);
        // negative span: box-only test over the whole coordinate range
        push_item(tvpt_pkg::CMD_WR_TRIG, 10'd5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
        push_item(tvpt_pkg::CMD_WR_TRIG, 10'd6, 32'd7, 32'd7, 32'd7, 32'd9, 32'd9, 32'd9,
                  16'd20);
        push_item(tvpt_pkg::CMD_QUERY, 10'd5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  0, 0, 0, 0);
        push_item(tvpt_pkg::CMD_QUERY, 10'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  0, 0, 0, 0);
        // single-point box with an empty plane span
        push_item(tvpt_pkg::CMD_WR_TRIG, 10'd7, 32'd100, -32'sd5, 32'd0, 32'd100, -32'sd5,
                  32'd0, 16'd28);
        push_item(tvpt_pkg::CMD_WR_TRIG, 10'd8, 0, 0, 0, 32'd10, 32'd10, 32'd10, 16'd28);
        push_item(tvpt_pkg::CMD_QUERY, 10'd7, 32'd100, -32'sd5, 32'd0, 0, 0, 0, 0);
        push_item(tvpt_pkg::CMD_QUERY, 10'd7, 32'd101, -32'sd5, 32'd0, 0, 0, 0, 0);
        push_item(tvpt_pkg::CMD_QUERY, 10'd6, 32'd6, 32'd8, 32'd8, 0, 0, 0, 0);
        // plane walk clamped at the end of the plane table
        push_item(tvpt_pkg::CMD_WR_PLANE, 10'd1023, '1, '1, '1, '1, '1, '1, 0);
        push_item(tvpt_pkg::CMD_WR_TRIG, 10'd254, 32'hFFFF_0000, 32'hFFFF_0000,
                  32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'd1020);
        push_item(tvpt_pkg::CMD_WR_TRIG, 10'd255, 0, 0, 0, 0, 0, 0, 16'hFFFF);
        push_item(tvpt_pkg::CMD_QUERY, 10'd254, 0, 0, 0, 0, 0, 0, 0);
        push_item(tvpt_pkg::CMD_QUERY, 10'd254, 32'h0000_8000, 32'hFFFF_8000, 0,
                  0, 0, 0, 0);
        push_item(tvpt_pkg::CMD_QUERY, 10'd256, 0, 0, 0, 0, 0, 0, 0);
        drain();
        push_trigger(10'd254);
        push_trigger(10'd255);
        drain();

        // Random phases, each under its own register setting and idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(tvpt_pkg::REG_TRIGGER_COUNT, 11'd255);
                    write_reg(tvpt_pkg::REG_PLANE_TOTAL, 11'd1024);
                end
                1: begin
                    write_reg(tvpt_pkg::REG_TRIGGER_COUNT, 11'($urandom_range(1, 255)));
                    write_reg(tvpt_pkg::REG_PLANE_TOTAL, 11'($urandom_range(0, 1024)));
                end
                2: begin
                    write_reg(tvpt_pkg::REG_TRIGGER_COUNT, 11'd255);
                    write_reg(tvpt_pkg::REG_PLANE_TOTAL, 11'($urandom_range(0, 1024)));
                end
                default: begin
                    write_reg(tvpt_pkg::REG_TRIGGER_COUNT, 11'($urandom_range(0, 255)));
                    write_reg(tvpt_pkg::REG_PLANE_TOTAL, 11'd1024);
                end
            endcase
            gap_pct = pcts[ph];
            for (int n = 0; n < 80; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    t = ($urandom_range(0, 19) == 0) ? 10'($urandom) :
                        10'($urandom_range(0, trig_count_sh));
                    push_query(t);
                end else if (pick < 90) begin
                    push_trigger(($urandom_range(0, 19) == 0) ? 10'($urandom) :
                                 10'($urandom_range(0, 255)));
                end else if (pick < 98) begin
                    push_plane(10'($urandom));
                end else begin
                    push_item(tvpt_pkg::CMD_NONE, 10'($urandom), $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, 16'($urandom));
                end
            end
            drain();
        end

        repeat (50) @(negedge i_clk);
        while (expected_hits.size() != 0) begin
            void'(expected_hits.pop_front());
            report("query result never arrived");
        end
        if (errors == 0) begin
            $display("PASS trigger_volume_point_test");
        end else begin
            $display("FAIL trigger_volume_point_test");
        end
        $finish;
    end

endmodule
